[design/gcob_pkg.sv]
// Shared constants, types and helper functions of the grid cell owner binning core.
`timescale 1ns / 1ps
package gcob_pkg;

  // Sizing of the block
  localparam int MAX_PARTS  = 16;
  localparam int MAX_NODES  = 8;
  localparam int COORD_BITS = 32;
  localparam int DIRS       = 3;

  // Derived widths
  localparam int PART_W      = $clog2(MAX_PARTS);
  localparam int PCNT_W      = PART_W + 1;
  localparam int CNT_W       = $clog2(MAX_NODES + 1);
  localparam int SUM_W       = COORD_BITS + $clog2(MAX_NODES);
  localparam int PROD_W      = COORD_BITS + CNT_W + 1;
  localparam int BP_DEPTH    = DIRS * MAX_PARTS;
  localparam int BP_ADDR_W   = $clog2(BP_DEPTH);
  localparam int M1_W        = PART_W + PCNT_W;
  localparam int FULL_W      = M1_W + PCNT_W + 1;

  // Fixed field widths
  localparam int CFG_PARTS_W = 5;
  localparam int DIRS_W      = 2;
  localparam int RANK_W      = 13;
  localparam int OWNER_W     = 12;
  localparam int IDX_W       = 4;

  // Cell job queue
  localparam int QDEPTH = 2;
  localparam int QPTR_W = 1;
  localparam int QCNT_W = 2;

  // Register port
  localparam int APB_ADDR_W = 5;
  localparam int APB_DATA_W = 32;
  localparam int REG_IDX_W  = 3;

  localparam logic [REG_IDX_W-1:0] REG_PARTS_X    = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_PARTS_Y    = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_PARTS_Z    = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_NUM_DIRS   = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RANK_COUNT = 3'd4;

  // Register reset values
  localparam logic [CFG_PARTS_W-1:0] PARTS_RST = 5'd1;
  localparam logic [DIRS_W-1:0]      DIRS_RST  = 2'd3;
  localparam logic [RANK_W-1:0]      RANK_RST  = 13'd1;

  // Request and direction codes
  localparam logic REQ_LOAD = 1'b0;
  localparam logic REQ_NODE = 1'b1;

  localparam logic [DIRS_W-1:0] DIR_X      = 2'd0;
  localparam logic [DIRS_W-1:0] DIR_Y      = 2'd1;
  localparam logic [DIRS_W-1:0] DIR_Z      = 2'd2;
  localparam logic [DIRS_W-1:0] NUM_DIRS_3 = 2'd3;

  typedef struct packed {
    logic [CFG_PARTS_W-1:0] parts_x;
    logic [CFG_PARTS_W-1:0] parts_y;
    logic [CFG_PARTS_W-1:0] parts_z;
    logic [DIRS_W-1:0]      num_dirs;
    logic [RANK_W-1:0]      rank_count;
  } gcob_cfg_t;

  // One closed cell: coordinate sums and node count
  typedef struct packed {
    logic [DIRS-1:0][SUM_W-1:0] sum;
    logic [CNT_W-1:0]           cnt;
  } gcob_job_t;

  typedef struct packed {
    logic empty;
    logic full;
  } gcob_qstat_t;

  // Clamp a part count register to 1 .. MAX_PARTS
  function automatic logic [PCNT_W-1:0] eff_parts(input logic [CFG_PARTS_W-1:0] p);
    logic [PCNT_W-1:0] r;
    if (p == '0) begin
      r = PCNT_W'(1);
    end else if (int'(p) > MAX_PARTS) begin
      r = PCNT_W'(MAX_PARTS);
    end else begin
      r = PCNT_W'(p);
    end
    return r;
  endfunction

  // Breakpoint table address of one direction and part
  function automatic logic [BP_ADDR_W-1:0] bp_addr(input logic [DIRS_W-1:0] dir,
                                                   input logic [PART_W-1:0] idx);
    return BP_ADDR_W'(dir) * BP_ADDR_W'(MAX_PARTS) + BP_ADDR_W'(idx);
  endfunction

endpackage

[design/grid_cell_owner_binning_core.sv]
// Top level: register port, front end, cell queue, breakpoint RAM and back end.
`timescale 1ns / 1ps
// Breakpoint loads and node transactions enter on the in_ channel; each node marked
// last yields one result on the out_ channel. A closed cell waits in a two-deep
// queue until the back end takes it and bins it: each breakpoint examined is read
// on the single read port of the breakpoint RAM and then compared, the scan of a
// direction stops at the first breakpoint not below the centre or at its last
// part, and the owner is then formed in a multiply step and a sum step. A scan
// reads at most as many breakpoints as the direction's part count, clamped to
// 1 .. 16, and the finished result waits while the result register is stalled.
// Node transactions of later cells keep flowing meanwhile; a breakpoint load is held
// until every queued cell has been binned, and a closing node is held while the
// queue is full. There is no clearing pass after reset: table entries must be
// loaded before a cell is binned against them.
module grid_cell_owner_binning_core (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_valid,
  output logic                                   in_stall,
  input  logic                                   in_req_type,
  input  logic [gcob_pkg::DIRS_W-1:0]            in_bp_dir,
  input  logic [gcob_pkg::IDX_W-1:0]             in_bp_index,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_bp_value,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_x,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_y,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_z,
  input  logic                                   in_last_node,
  output logic                                   out_valid,
  input  logic                                   out_stall,
  output logic [gcob_pkg::OWNER_W-1:0]           out_owner,
  output logic [gcob_pkg::IDX_W-1:0]             out_part_x,
  output logic [gcob_pkg::IDX_W-1:0]             out_part_y,
  output logic [gcob_pkg::IDX_W-1:0]             out_part_z,
  output logic                                   out_bad_owner,
  input  logic                                   psel,
  input  logic                                   penable,
  input  logic                                   pwrite,
  input  logic [gcob_pkg::APB_ADDR_W-1:0]        paddr,
  input  logic [gcob_pkg::APB_DATA_W-1:0]        pwdata,
  output logic [gcob_pkg::APB_DATA_W-1:0]        prdata,
  output logic                                   pready
);

  gcob_pkg::gcob_cfg_t              cfg_r, cfg_nxt;
  logic [gcob_pkg::REG_IDX_W-1:0]   reg_idx;
  logic                             reg_wr;
  gcob_pkg::gcob_qstat_t            qstat;
  gcob_pkg::gcob_job_t              push_job, pop_job;
  logic                             push, pop, back_busy;
  logic                             bp_we, bp_re;
  logic [gcob_pkg::BP_ADDR_W-1:0]   bp_waddr, bp_raddr;
  logic [gcob_pkg::COORD_BITS-1:0]  bp_wdata, bp_rdata;

  // Register port
  assign pready  = 1'b1;
  assign reg_idx = paddr[gcob_pkg::APB_ADDR_W-1:2];
  assign reg_wr  = psel && penable && pwrite && pready;

  always_comb begin
    cfg_nxt = cfg_r;
    if (reg_wr) begin
      unique case (reg_idx)
        gcob_pkg::REG_PARTS_X:    cfg_nxt.parts_x    = pwdata[gcob_pkg::CFG_PARTS_W-1:0];
        gcob_pkg::REG_PARTS_Y:    cfg_nxt.parts_y    = pwdata[gcob_pkg::CFG_PARTS_W-1:0];
        gcob_pkg::REG_PARTS_Z:    cfg_nxt.parts_z    = pwdata[gcob_pkg::CFG_PARTS_W-1:0];
        gcob_pkg::REG_NUM_DIRS:   cfg_nxt.num_dirs   = pwdata[gcob_pkg::DIRS_W-1:0];
        gcob_pkg::REG_RANK_COUNT: cfg_nxt.rank_count = pwdata[gcob_pkg::RANK_W-1:0];
        default:                  cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.parts_x    <= gcob_pkg::PARTS_RST;
      cfg_r.parts_y    <= gcob_pkg::PARTS_RST;
      cfg_r.parts_z    <= gcob_pkg::PARTS_RST;
      cfg_r.num_dirs   <= gcob_pkg::DIRS_RST;
      cfg_r.rank_count <= gcob_pkg::RANK_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // Register read back
  always_comb begin
    unique case (reg_idx)
      gcob_pkg::REG_PARTS_X:    prdata = gcob_pkg::APB_DATA_W'(cfg_r.parts_x);
      gcob_pkg::REG_PARTS_Y:    prdata = gcob_pkg::APB_DATA_W'(cfg_r.parts_y);
      gcob_pkg::REG_PARTS_Z:    prdata = gcob_pkg::APB_DATA_W'(cfg_r.parts_z);
      gcob_pkg::REG_NUM_DIRS:   prdata = gcob_pkg::APB_DATA_W'(cfg_r.num_dirs);
      gcob_pkg::REG_RANK_COUNT: prdata = gcob_pkg::APB_DATA_W'(cfg_r.rank_count);
      default:                  prdata = '0;
    endcase
  end

  gcob_front u_front (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_req_type  (in_req_type),
    .in_bp_dir    (in_bp_dir),
    .in_bp_index  (in_bp_index),
    .in_bp_value  (in_bp_value),
    .in_node_x    (in_node_x),
    .in_node_y    (in_node_y),
    .in_node_z    (in_node_z),
    .in_last_node (in_last_node),
    .qstat        (qstat),
    .back_busy    (back_busy),
    .push         (push),
    .push_job     (push_job),
    .bp_we        (bp_we),
    .bp_waddr     (bp_waddr),
    .bp_wdata     (bp_wdata)
  );

  gcob_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_job (push_job),
    .pop      (pop),
    .pop_job  (pop_job),
    .stat     (qstat)
  );

  gcob_ram #(
    .WIDTH (gcob_pkg::COORD_BITS),
    .DEPTH (gcob_pkg::BP_DEPTH)
  ) u_bp_ram (
    .clk   (clk),
    .we    (bp_we),
    .waddr (bp_waddr),
    .wdata (bp_wdata),
    .re    (bp_re),
    .raddr (bp_raddr),
    .rdata (bp_rdata)
  );

  gcob_back u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg_r),
    .qstat         (qstat),
    .pop_job       (pop_job),
    .pop           (pop),
    .busy          (back_busy),
    .bp_re         (bp_re),
    .bp_raddr      (bp_raddr),
    .bp_rdata      (bp_rdata),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_owner     (out_owner),
    .out_part_x    (out_part_x),
    .out_part_y    (out_part_y),
    .out_part_z    (out_part_z),
    .out_bad_owner (out_bad_owner)
  );

endmodule

[design/gcob_ram.sv]
// Generic single write port, single read port RAM with registered read data.
`timescale 1ns / 1ps
module gcob_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 48
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write and registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[design/gcob_queue.sv]
// Two-entry queue of closed cells between the front and the back.
`timescale 1ns / 1ps
module gcob_queue (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    push,
  input  gcob_pkg::gcob_job_t     push_job,
  input  logic                    pop,
  output gcob_pkg::gcob_job_t     pop_job,
  output gcob_pkg::gcob_qstat_t   stat
);

  gcob_pkg::gcob_job_t                 ent_r [gcob_pkg::QDEPTH];
  logic [gcob_pkg::QPTR_W-1:0]         wr_ptr_r, wr_ptr_nxt;
  logic [gcob_pkg::QPTR_W-1:0]         rd_ptr_r, rd_ptr_nxt;
  logic [gcob_pkg::QCNT_W-1:0]         cnt_r, cnt_nxt;

  // Pointer and fill count update
  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = rd_ptr_r + 1'b1;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  // Store the pushed cell
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wr_ptr_r] <= push_job;
    end
  end

  assign pop_job    = ent_r[rd_ptr_r];
  assign stat.empty = (cnt_r == '0);
  assign stat.full  = (cnt_r == gcob_pkg::QCNT_W'(gcob_pkg::QDEPTH));

endmodule

[design/gcob_front.sv]
// Front end: accepts transactions, loads breakpoints and accumulates node sums.
`timescale 1ns / 1ps
module gcob_front (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 in_valid,
  output logic                                 in_stall,
  input  logic                                 in_req_type,
  input  logic [gcob_pkg::DIRS_W-1:0]          in_bp_dir,
  input  logic [gcob_pkg::IDX_W-1:0]           in_bp_index,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_bp_value,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_x,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_y,
  input  logic signed [gcob_pkg::COORD_BITS-1:0] in_node_z,
  input  logic                                 in_last_node,
  input  gcob_pkg::gcob_qstat_t                qstat,
  input  logic                                 back_busy,
  output logic                                 push,
  output gcob_pkg::gcob_job_t                  push_job,
  output logic                                 bp_we,
  output logic [gcob_pkg::BP_ADDR_W-1:0]       bp_waddr,
  output logic [gcob_pkg::COORD_BITS-1:0]      bp_wdata
);

  logic [gcob_pkg::DIRS-1:0][gcob_pkg::SUM_W-1:0] sum_r, sum_nxt;
  logic [gcob_pkg::CNT_W-1:0]                     cnt_r, cnt_nxt;
  logic [gcob_pkg::DIRS-1:0][gcob_pkg::SUM_W-1:0] sum_add;
  logic [gcob_pkg::CNT_W-1:0]                     cnt_add;
  logic                                           accept;
  logic                                           room;

  // Hold loads while a cell is queued or searched; hold a closing node on a full queue
  always_comb begin
    if (in_req_type == gcob_pkg::REQ_LOAD) begin
      in_stall = !qstat.empty || back_busy;
    end else begin
      in_stall = in_last_node && qstat.full;
    end
  end

  assign accept = in_valid && !in_stall;

  // Breakpoint write, out-of-range directions dropped
  assign bp_we    = accept && (in_req_type == gcob_pkg::REQ_LOAD) &&
                    (int'(in_bp_dir) < gcob_pkg::DIRS) &&
                    (int'(in_bp_index) < gcob_pkg::MAX_PARTS);
  assign bp_waddr = gcob_pkg::bp_addr(in_bp_dir, gcob_pkg::PART_W'(in_bp_index));
  assign bp_wdata = in_bp_value;

  // Add the node unless the cell already holds its maximum node count
  always_comb begin
    room = (int'(cnt_r) < gcob_pkg::MAX_NODES);
    sum_add = sum_r;
    cnt_add = cnt_r;
    if (room) begin
      sum_add[gcob_pkg::DIR_X] = sum_r[gcob_pkg::DIR_X] + gcob_pkg::SUM_W'(in_node_x);
      sum_add[gcob_pkg::DIR_Y] = sum_r[gcob_pkg::DIR_Y] + gcob_pkg::SUM_W'(in_node_y);
      sum_add[gcob_pkg::DIR_Z] = sum_r[gcob_pkg::DIR_Z] + gcob_pkg::SUM_W'(in_node_z);
      cnt_add = cnt_r + 1'b1;
    end
  end

  // Accumulate, and close the cell on its last node
  always_comb begin
    sum_nxt      = sum_r;
    cnt_nxt      = cnt_r;
    push         = 1'b0;
    push_job.sum = sum_add;
    push_job.cnt = cnt_add;
    if (accept && (in_req_type == gcob_pkg::REQ_NODE)) begin
      if (in_last_node) begin
        push    = 1'b1;
        sum_nxt = '0;
        cnt_nxt = '0;
      end else begin
        sum_nxt = sum_add;
        cnt_nxt = cnt_add;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sum_r <= '0;
      cnt_r <= '0;
    end else begin
      sum_r <= sum_nxt;
      cnt_r <= cnt_nxt;
    end
  end

endmodule

[design/gcob_back.sv]
// Back end: breakpoint search per direction, owner arithmetic and result register.
`timescale 1ns / 1ps
module gcob_back (
  input  logic                              clk,
  input  logic                              rst_n,
  input  gcob_pkg::gcob_cfg_t               cfg,
  input  gcob_pkg::gcob_qstat_t             qstat,
  input  gcob_pkg::gcob_job_t               pop_job,
  output logic                              pop,
  output logic                              busy,
  output logic                              bp_re,
  output logic [gcob_pkg::BP_ADDR_W-1:0]    bp_raddr,
  input  logic [gcob_pkg::COORD_BITS-1:0]   bp_rdata,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic [gcob_pkg::OWNER_W-1:0]      out_owner,
  output logic [gcob_pkg::IDX_W-1:0]        out_part_x,
  output logic [gcob_pkg::IDX_W-1:0]        out_part_y,
  output logic [gcob_pkg::IDX_W-1:0]        out_part_z,
  output logic                              out_bad_owner
);

  typedef enum logic [4:0] {
    ST_IDLE = 5'b00001,
    ST_READ = 5'b00010,
    ST_CMP  = 5'b00100,
    ST_MUL  = 5'b01000,
    ST_SUM  = 5'b10000
  } state_t;

  state_t                                   state_r, state_nxt;
  gcob_pkg::gcob_job_t                      job_r, job_nxt;
  logic [gcob_pkg::DIRS_W-1:0]              dir_r, dir_nxt;
  logic [gcob_pkg::PART_W-1:0]              idx_r, idx_nxt;
  logic [gcob_pkg::PART_W-1:0]              cur_r, cur_nxt;
  logic [gcob_pkg::DIRS-1:0][gcob_pkg::PART_W-1:0] part_r, part_nxt;
  logic [gcob_pkg::M1_W-1:0]                m1_r, m1_nxt, m2_r, m2_nxt;
  logic                                     out_valid_r, out_valid_nxt;
  logic [gcob_pkg::OWNER_W-1:0]             owner_r, owner_nxt;
  logic [gcob_pkg::DIRS-1:0][gcob_pkg::IDX_W-1:0] opart_r, opart_nxt;
  logic                                     bad_r, bad_nxt;

  logic [gcob_pkg::PCNT_W-1:0]              nx, ny, nz, n_cur;
  logic                                     three;
  logic signed [gcob_pkg::SUM_W-1:0]        sum_cur;
  logic signed [gcob_pkg::COORD_BITS-1:0]   bp;
  logic signed [gcob_pkg::CNT_W:0]          cnt_s;
  logic signed [gcob_pkg::PROD_W-1:0]       scaled;
  logic                                     above;
  logic                                     last_entry;
  logic [gcob_pkg::PART_W-1:0]              found;
  logic [gcob_pkg::FULL_W-1:0]              full;

  // Effective part counts
  assign nx    = gcob_pkg::eff_parts(cfg.parts_x);
  assign ny    = gcob_pkg::eff_parts(cfg.parts_y);
  assign nz    = gcob_pkg::eff_parts(cfg.parts_z);
  assign three = (cfg.num_dirs == gcob_pkg::NUM_DIRS_3);

  always_comb begin
    case (dir_r)
      gcob_pkg::DIR_X: n_cur = nx;
      gcob_pkg::DIR_Y: n_cur = ny;
      default:         n_cur = nz;
    endcase
  end

  // Compare centre against breakpoint without dividing: sum > bp * count
  always_comb begin
    sum_cur    = $signed(job_r.sum[dir_r]);
    bp         = $signed(bp_rdata);
    cnt_s      = $signed({1'b0, job_r.cnt});
    scaled     = bp * cnt_s;
    above      = gcob_pkg::PROD_W'(sum_cur) > scaled;
    last_entry = (gcob_pkg::PCNT_W'(idx_r) + 1'b1) >= n_cur;
    found      = above ? idx_r : cur_r;
  end

  assign bp_re    = (state_r == ST_READ);
  assign bp_raddr = gcob_pkg::bp_addr(dir_r, idx_r);

  // Owner sum from registered products, with the z product scaled by ny here
  assign full = gcob_pkg::FULL_W'(part_r[gcob_pkg::DIR_X]) + gcob_pkg::FULL_W'(m1_r) +
                gcob_pkg::FULL_W'(m2_r) * gcob_pkg::FULL_W'(ny);

  // Sequencer
  always_comb begin
    state_nxt     = state_r;
    job_nxt       = job_r;
    dir_nxt       = dir_r;
    idx_nxt       = idx_r;
    cur_nxt       = cur_r;
    part_nxt      = part_r;
    m1_nxt        = m1_r;
    m2_nxt        = m2_r;
    out_valid_nxt = out_valid_r;
    owner_nxt     = owner_r;
    opart_nxt     = opart_r;
    bad_nxt       = bad_r;
    pop           = 1'b0;

    // Drop the result once taken
    if (out_valid_r && !out_stall) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (!qstat.empty) begin
          pop       = 1'b1;
          job_nxt   = pop_job;
          dir_nxt   = gcob_pkg::DIR_X;
          idx_nxt   = '0;
          cur_nxt   = '0;
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        state_nxt = ST_CMP;
      end
      ST_CMP: begin
        if (above && !last_entry) begin
          cur_nxt   = idx_r;
          idx_nxt   = idx_r + 1'b1;
          state_nxt = ST_READ;
        end else begin
          part_nxt[dir_r] = found;
          idx_nxt         = '0;
          cur_nxt         = '0;
          if (dir_r == gcob_pkg::DIR_X) begin
            dir_nxt   = gcob_pkg::DIR_Y;
            state_nxt = ST_READ;
          end else if (dir_r == gcob_pkg::DIR_Y && three) begin
            dir_nxt   = gcob_pkg::DIR_Z;
            state_nxt = ST_READ;
          end else begin
            if (dir_r == gcob_pkg::DIR_Y) begin
              part_nxt[gcob_pkg::DIR_Z] = '0;
            end
            state_nxt = ST_MUL;
          end
        end
      end
      ST_MUL: begin
        m1_nxt    = gcob_pkg::M1_W'(part_r[gcob_pkg::DIR_Y]) * gcob_pkg::M1_W'(nx);
        m2_nxt    = gcob_pkg::M1_W'(part_r[gcob_pkg::DIR_Z]) * gcob_pkg::M1_W'(nx);
        state_nxt = ST_SUM;
      end
      ST_SUM: begin
        // Load the result register once it is free
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1;
          owner_nxt     = full[gcob_pkg::OWNER_W-1:0];
          opart_nxt[gcob_pkg::DIR_X] = gcob_pkg::IDX_W'(part_r[gcob_pkg::DIR_X]);
          opart_nxt[gcob_pkg::DIR_Y] = gcob_pkg::IDX_W'(part_r[gcob_pkg::DIR_Y]);
          opart_nxt[gcob_pkg::DIR_Z] = gcob_pkg::IDX_W'(part_r[gcob_pkg::DIR_Z]);
          bad_nxt       = full >= gcob_pkg::FULL_W'(cfg.rank_count);
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Datapath registers
  always_ff @(posedge clk) begin
    job_r   <= job_nxt;
    dir_r   <= dir_nxt;
    idx_r   <= idx_nxt;
    cur_r   <= cur_nxt;
    part_r  <= part_nxt;
    m1_r    <= m1_nxt;
    m2_r    <= m2_nxt;
    owner_r <= owner_nxt;
    opart_r <= opart_nxt;
    bad_r   <= bad_nxt;
  end

  assign busy          = (state_r != ST_IDLE);
  assign out_valid     = out_valid_r;
  assign out_owner     = owner_r;
  assign out_part_x    = opart_r[gcob_pkg::DIR_X];
  assign out_part_y    = opart_r[gcob_pkg::DIR_Y];
  assign out_part_z    = opart_r[gcob_pkg::DIR_Z];
  assign out_bad_owner = bad_r;

endmodule

[design/gcob_checker.sv]
// Port-level checker for the grid cell owner binning core, with its bind.
`timescale 1ns / 1ps
module gcob_checker (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_stall,
  input logic                              in_req_type,
  input logic                              in_last_node,
  input logic                              psel,
  input logic                              penable,
  input logic                              pwrite,
  input logic                              pready,
  input logic [gcob_pkg::APB_ADDR_W-1:0]   paddr,
  input logic [gcob_pkg::APB_DATA_W-1:0]   pwdata,
  input logic                              out_valid,
  input logic                              out_stall,
  input logic [gcob_pkg::OWNER_W-1:0]      out_owner,
  input logic [gcob_pkg::IDX_W-1:0]        out_part_z
);

  logic [gcob_pkg::DIRS_W-1:0] dirs_r;

  // Track the direction count register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dirs_r <= gcob_pkg::DIRS_RST;
    end else if (psel && penable && pwrite && pready &&
                 paddr[gcob_pkg::APB_ADDR_W-1:2] == gcob_pkg::REG_NUM_DIRS) begin
      dirs_r <= pwdata[gcob_pkg::DIRS_W-1:0];
    end
  end

  // Reset empties the result register
  a_reset_clears_out: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  // A stalled result holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_owner))
    else $error("stalled result changed");

  // Nodes that do not close a cell are never held back
  a_node_flows: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_req_type == gcob_pkg::REQ_NODE && !in_last_node |-> !in_stall)
    else $error("open-cell node stalled");

  // Two-direction grids report part_z as zero
  a_2d_part_z: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && dirs_r != gcob_pkg::NUM_DIRS_3 |-> out_part_z == '0)
    else $error("nonzero part_z with two directions");

endmodule

bind grid_cell_owner_binning_core gcob_checker u_gcob_checker (.*);
